// File: rtl/lbe_pkg.sv
// Shared types, constants and the color reorder function of the LED bit encoder.
package lbe_pkg;

	// Field widths
	localparam int PIXEL_W     = 24;
	localparam int TICK_W      = 15;
	localparam int ORDER_W     = 3;
	localparam int LED_CNT_W   = 11;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 15;

	// Bits sent for one LED, most significant first
	localparam int BITS_PER_LED = 24;
	localparam int BIT_CNT_W    = $clog2(BITS_PER_LED);
	localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(BITS_PER_LED - 1);

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Color byte masks on the input pixel
	localparam logic [PIXEL_W-1:0] RED_MASK   = 24'hFF0000;
	localparam logic [PIXEL_W-1:0] GREEN_MASK = 24'h00FF00;
	localparam logic [PIXEL_W-1:0] BLUE_MASK  = 24'h0000FF;

	// Wire byte orders
	localparam logic [ORDER_W-1:0] ORDER_RGB = 3'd0;
	localparam logic [ORDER_W-1:0] ORDER_RBG = 3'd1;
	localparam logic [ORDER_W-1:0] ORDER_GRB = 3'd2;
	localparam logic [ORDER_W-1:0] ORDER_GBR = 3'd3;
	localparam logic [ORDER_W-1:0] ORDER_BRG = 3'd4;
	localparam logic [ORDER_W-1:0] ORDER_BGR = 3'd5;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_ORDER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOW         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT   = 3'd4;

	// Register reset values
	localparam logic [ORDER_W-1:0]   RST_COLOR_ORDER = ORDER_RGB;
	localparam logic [TICK_W-1:0]    RST_ONE_HIGH    = 15'd32;
	localparam logic [TICK_W-1:0]    RST_ZERO_HIGH   = 15'd16;
	localparam logic [TICK_W-1:0]    RST_LOW         = 15'd34;
	localparam logic [LED_CNT_W-1:0] RST_LED_COUNT   = 11'd1;

	typedef struct packed {
		logic [ORDER_W-1:0]   color_order;
		logic [TICK_W-1:0]    one_high_ticks;
		logic [TICK_W-1:0]    zero_high_ticks;
		logic [TICK_W-1:0]    low_ticks;
		logic [LED_CNT_W-1:0] led_count;
	} lbe_cfg_t;

	// One classified pixel waiting for the back end
	typedef struct packed {
		logic [PIXEL_W-1:0] word;
		logic               frame_end;
	} lbe_job_t;

	// Queue status seen by the front end, the back end and the top level
	typedef struct packed {
		logic not_empty;
		logic full;
	} lbe_q_stat_t;

	// Put the color bytes into wire order; unused codes pass as RGB
	function automatic logic [PIXEL_W-1:0] lbe_reorder(input logic [ORDER_W-1:0] order,
			input logic [PIXEL_W-1:0] pixel);
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [PIXEL_W-1:0] word;
		r = 8'((pixel & RED_MASK) >> 16);
		g = 8'((pixel & GREEN_MASK) >> 8);
		b = 8'(pixel & BLUE_MASK);
		unique case (order)
			ORDER_RBG: word = {r, b, g};
			ORDER_GRB: word = {g, r, b};
			ORDER_GBR: word = {g, b, r};
			ORDER_BRG: word = {b, r, g};
			ORDER_BGR: word = {b, g, r};
			default:   word = {r, g, b};
		endcase
		return word;
	endfunction

endpackage

// File: rtl/lbe_if.sv
// Request channels for pixels in and bit pulses out.
interface lbe_pixel_if import lbe_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface lbe_pulse_if import lbe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TICK_W-1:0] high_ticks;
	logic [TICK_W-1:0] low_ticks_out;
	logic              bit_value;
	logic              last_of_pixel;
	logic              last_of_frame;

	modport source (output valid, output high_ticks, output low_ticks_out, output bit_value,
		output last_of_pixel, output last_of_frame, input ready);
	modport sink   (input valid, input high_ticks, input low_ticks_out, input bit_value,
		input last_of_pixel, input last_of_frame, output ready);
endinterface

// File: rtl/lbe_front.sv
// Front end: accept pixels, reorder bytes and mark the pixel that ends a frame.
module lbe_front import lbe_pkg::*; #(
	parameter int MAX_LEDS = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	lbe_pixel_if.sink    pixel_in,
	input  lbe_cfg_t     cfg,
	input  lbe_q_stat_t  q_stat,
	output logic         push,
	output lbe_job_t     job
);

	localparam int IDX_W  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam int MAX_W  = $clog2(MAX_LEDS + 1);
	localparam int CW0    = (IDX_W > LED_CNT_W) ? IDX_W : LED_CNT_W;
	localparam int CW     = (MAX_W > CW0) ? MAX_W : CW0;

	logic [IDX_W-1:0] pixel_index_q;
	logic [CW-1:0]    count;
	logic [CW-1:0]    count_raw;
	logic             frame_end;

	// Accept whenever the queue has room
	assign pixel_in.ready = !q_stat.full;
	assign push           = pixel_in.valid && !q_stat.full;

	// Clamp the LED count to one through MAX_LEDS
	always_comb begin
		count_raw = CW'(cfg.led_count);
		if (count_raw == '0) begin
			count = CW'(1);
		end else if (count_raw > CW'(MAX_LEDS)) begin
			count = CW'(MAX_LEDS);
		end else begin
			count = count_raw;
		end
	end

	assign frame_end     = CW'(pixel_index_q) >= (count - CW'(1));
	assign job.word      = lbe_reorder(cfg.color_order, pixel_in.pixel);
	assign job.frame_end = frame_end;

	// Advance the pixel position, wrap at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_index_q <= '0;
		end else if (push) begin
			if (frame_end) begin
				pixel_index_q <= '0;
			end else begin
				pixel_index_q <= pixel_index_q + 1'b1;
			end
		end
	end

endmodule

// File: rtl/lbe_queue.sv
// Short queue of classified pixels between front and back ends.
module lbe_queue import lbe_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  lbe_job_t    push_job,
	input  logic        pop,
	output lbe_job_t    head,
	output lbe_q_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lbe_job_t          mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign head           = mem_q[rd_ptr_q];
	assign stat.not_empty = count_q != '0;
	assign stat.full      = count_q == CNT_W'(DEPTH);

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Move pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/lbe_back.sv
// Back end: shift a pixel out as 24 bit pulses through an output register.
module lbe_back import lbe_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  lbe_cfg_t     cfg,
	input  lbe_q_stat_t  q_stat,
	input  lbe_job_t     head,
	output logic         pop,
	lbe_pulse_if.source  pulse_out
);

	logic [PIXEL_W-1:0]   word_q;
	logic                 frame_end_q;
	logic                 busy_q;
	logic [BIT_CNT_W-1:0] bit_cnt_q;
	logic                 out_valid_q;
	logic                 advance;
	logic                 emit;
	logic                 last_bit;

	assign advance  = !out_valid_q || pulse_out.ready;
	assign emit     = advance && busy_q;
	assign last_bit = bit_cnt_q == LAST_BIT;
	assign pop      = q_stat.not_empty && (!busy_q || (emit && last_bit));

	// Load the next pixel or shift to the next bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			bit_cnt_q <= '0;
		end else if (pop) begin
			busy_q    <= 1'b1;
			bit_cnt_q <= '0;
		end else if (emit) begin
			bit_cnt_q <= bit_cnt_q + 1'b1;
			if (last_bit) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q      <= head.word;
			frame_end_q <= head.frame_end;
		end else if (emit) begin
			word_q <= word_q << 1;
		end
	end

	// Hold the pulse until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pulse_out.high_ticks    <= word_q[PIXEL_W-1] ? cfg.one_high_ticks
				: cfg.zero_high_ticks;
			pulse_out.low_ticks_out <= cfg.low_ticks;
			pulse_out.bit_value     <= word_q[PIXEL_W-1];
			pulse_out.last_of_pixel <= last_bit;
			pulse_out.last_of_frame <= last_bit && frame_end_q;
		end
	end

	assign pulse_out.valid = out_valid_q;

endmodule

// File: rtl/addressable_led_bit_pulse_encoder_core.sv
// The first pulse of a pixel passes the queue entry, the back end shift register and the output register.
// Each pixel gives 24 pulses, one pulse per cycle while the pulse output is ready, counted by the back end bit counter.
// A two-entry queue lets the front end take the next pixel while a pixel is shifting out.
// Reset: registers return to RGB order, 32/16/34 ticks and one LED; the pixel index is zero.
// Reset also empties the queue and drops any pending pulse.
module addressable_led_bit_pulse_encoder_core import lbe_pkg::*; #(
	parameter int MAX_LEDS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	lbe_pixel_if.sink             pixel_in,
	lbe_pulse_if.source           pulse_out,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	lbe_cfg_t    cfg_q;
	lbe_q_stat_t q_stat;
	lbe_job_t    push_job;
	lbe_job_t    head;
	logic        push;
	logic        pop;

	// Write configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_order     <= RST_COLOR_ORDER;
			cfg_q.one_high_ticks  <= RST_ONE_HIGH;
			cfg_q.zero_high_ticks <= RST_ZERO_HIGH;
			cfg_q.low_ticks       <= RST_LOW;
			cfg_q.led_count       <= RST_LED_COUNT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLOR_ORDER: cfg_q.color_order     <= cfg_wdata[ORDER_W-1:0];
				REG_ONE_HIGH:    cfg_q.one_high_ticks  <= cfg_wdata[TICK_W-1:0];
				REG_ZERO_HIGH:   cfg_q.zero_high_ticks <= cfg_wdata[TICK_W-1:0];
				REG_LOW:         cfg_q.low_ticks       <= cfg_wdata[TICK_W-1:0];
				REG_LED_COUNT:   cfg_q.led_count       <= cfg_wdata[LED_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	lbe_front #(.MAX_LEDS(MAX_LEDS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixel_in (pixel_in),
		.cfg      (cfg_q),
		.q_stat   (q_stat),
		.push     (push),
		.job      (push_job)
	);

	lbe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	lbe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_stat    (q_stat),
		.head      (head),
		.pop       (pop),
		.pulse_out (pulse_out)
	);

	// A taken pixel is waiting in the queue on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_in.valid && pixel_in.ready) |=> q_stat.not_empty)
		else $error("queue empty after pixel request");

	// Never pop an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> q_stat.not_empty)
		else $error("pop from empty queue");

	// A frame ends only on the last bit of a pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		(pulse_out.valid && pulse_out.last_of_frame) |-> pulse_out.last_of_pixel)
		else $error("frame end off pixel boundary");

endmodule

// File: tb/addressable_led_bit_pulse_encoder_core_test.sv
// Self-checking testbench for the addressable LED bit pulse encoder core.
`timescale 1ns / 1ps

module addressable_led_bit_pulse_encoder_core_test;
	import lbe_pkg::*;

	localparam int MAX_LEDS    = 1024;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE      = 4;

	typedef struct packed {
		logic [TICK_W-1:0] high_ticks;
		logic [TICK_W-1:0] low_ticks_out;
		logic              bit_value;
		logic              last_of_pixel;
		logic              last_of_frame;
	} pulse_t;

	logic clk;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	lbe_pixel_if pixel_ch ();
	lbe_pulse_if pulse_ch ();

	addressable_led_bit_pulse_encoder_core #(
		.MAX_LEDS(MAX_LEDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_in(pixel_ch),
		.pulse_out(pulse_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Shadow copy of the register file and frame position
	logic [ORDER_W-1:0]   cur_order;
	logic [TICK_W-1:0]    cur_one_high;
	logic [TICK_W-1:0]    cur_zero_high;
	logic [TICK_W-1:0]    cur_low;
	logic [LED_CNT_W-1:0] cur_led_count;
	int                   frame_pos;

	pulse_t pending_pulses[$];
	int     mismatch_total;
	int     stall_cycles;
	int     src_idle_pct;
	int     snk_idle_pct;

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Expand one pixel into the pulses it must produce and advance the frame position
	function automatic void expand_pixel(input logic [PIXEL_W-1:0] pix);
		logic [7:0]         r;
		logic [7:0]         g;
		logic [7:0]         b;
		logic [PIXEL_W-1:0] word;
		int                 count;
		logic               frame_end;
		pulse_t             p;
		r = pix[23:16];
		g = pix[15:8];
		b = pix[7:0];
		case (cur_order)
			ORDER_RBG: word = {r, b, g};
			ORDER_GRB: word = {g, r, b};
			ORDER_GBR: word = {g, b, r};
			ORDER_BRG: word = {b, r, g};
			ORDER_BGR: word = {b, g, r};
			default:   word = {r, g, b};
		endcase
		count = (cur_led_count == '0) ? 1 : int'(cur_led_count);
		if (count > MAX_LEDS)
			count = MAX_LEDS;
		frame_end = (frame_pos >= count - 1);
		for (int i = 0; i < BITS_PER_LED; i++) begin
			p.bit_value     = word[BITS_PER_LED - 1 - i];
			p.high_ticks    = p.bit_value ? cur_one_high : cur_zero_high;
			p.low_ticks_out = cur_low;
			p.last_of_pixel = (i == BITS_PER_LED - 1);
			p.last_of_frame = p.last_of_pixel && frame_end;
			pending_pulses.push_back(p);
		end
		frame_pos = frame_end ? 0 : frame_pos + 1;
	endfunction

	function automatic void compare_field(input string name, input logic [TICK_W-1:0] want,
			input logic [TICK_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_total++;
		end
	endfunction

	// Check each accepted pulse against the oldest prediction; track stalled cycles
	always @(posedge clk) begin
		pulse_t want;
		if (pulse_ch.valid && pulse_ch.ready) begin
			if (pending_pulses.size() == 0) begin
				$error("pulse request with no pixel pending");
				mismatch_total++;
			end else begin
				want = pending_pulses.pop_front();
				compare_field("high_ticks", want.high_ticks, pulse_ch.high_ticks);
				compare_field("low_ticks_out", want.low_ticks_out, pulse_ch.low_ticks_out);
				compare_field("bit_value", TICK_W'(want.bit_value),
					TICK_W'(pulse_ch.bit_value));
				compare_field("last_of_pixel", TICK_W'(want.last_of_pixel),
					TICK_W'(pulse_ch.last_of_pixel));
				compare_field("last_of_frame", TICK_W'(want.last_of_frame),
					TICK_W'(pulse_ch.last_of_frame));
			end
		end
		if ((pulse_ch.valid && pulse_ch.ready) || (pixel_ch.valid && pixel_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	// Stall the pulse side at random
	always @(negedge clk) begin
		pulse_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// End the run if nothing moves for too long
	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// Send one pixel request, idling first at random; returns on a falling edge
	task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
		while ($urandom_range(99) < src_idle_pct) begin
			pixel_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pixel_ch.valid <= 1'b1;
		pixel_ch.pixel <= pix;
		do
			@(posedge clk);
		while (!pixel_ch.ready);
		expand_pixel(pix);
		@(negedge clk);
	endtask

	// Drop the pixel request and wait until every predicted pulse has come out
	task automatic drain;
		pixel_ch.valid <= 1'b0;
		while (pending_pulses.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Write one register and mirror it in the shadow copy
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_COLOR_ORDER: cur_order     = data[ORDER_W-1:0];
			REG_ONE_HIGH:    cur_one_high  = data[TICK_W-1:0];
			REG_ZERO_HIGH:   cur_zero_high = data[TICK_W-1:0];
			REG_LOW:         cur_low       = data[TICK_W-1:0];
			REG_LED_COUNT:   cur_led_count = data[LED_CNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	function automatic logic [TICK_W-1:0] pick_ticks;
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			2: return TICK_W'($urandom_range(1, 100));
			default: return TICK_W'($urandom);
		endcase
	endfunction

	// Choose a random register setting, extremes included, with noise in unused bits
	task automatic pick_settings;
		logic [LED_CNT_W-1:0] count;
		case ($urandom_range(3))
			0: count = '0;
			1: count = LED_CNT_W'($urandom_range(1, 6));
			2: count = LED_CNT_W'($urandom_range(7, 40));
			default: count = LED_CNT_W'($urandom);
		endcase
		write_reg(REG_COLOR_ORDER,
			{(CFG_DATA_W - ORDER_W)'($urandom), ORDER_W'($urandom)});
		write_reg(REG_ONE_HIGH, pick_ticks());
		write_reg(REG_ZERO_HIGH, pick_ticks());
		write_reg(REG_LOW, pick_ticks());
		write_reg(REG_LED_COUNT, {4'($urandom), count});
		if ($urandom_range(3) == 0)
			write_reg(CFG_IDX_W'($urandom_range(int'(REG_LED_COUNT) + 1, (1 << CFG_IDX_W) - 1)),
				CFG_DATA_W'($urandom));
	endtask

	task automatic set_idle(input int src_pct, input int snk_pct);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
	endtask

	// Reset values: timing and single-LED frames
	task automatic test_reset_values;
		send_pixel(24'hFFFFFF);
		send_pixel(24'h000000);
		send_pixel(24'hA5C3F0);
		drain();
	endtask

	// Every byte order, the two unused codes included
	task automatic test_color_orders;
		for (int k = 0; k < (1 << ORDER_W); k++) begin
			write_reg(REG_COLOR_ORDER, CFG_DATA_W'(k));
			send_pixel(24'hF0_3C_81);
			drain();
		end
		write_reg(REG_COLOR_ORDER, CFG_DATA_W'(ORDER_RGB));
	endtask

	// Full-scale and zero pulse widths
	task automatic test_pulse_extremes;
		write_reg(REG_ONE_HIGH, '1);
		write_reg(REG_ZERO_HIGH, '0);
		write_reg(REG_LOW, '1);
		send_pixel(24'hAAAA55);
		drain();
		write_reg(REG_ONE_HIGH, '0);
		write_reg(REG_ZERO_HIGH, '1);
		write_reg(REG_LOW, '0);
		send_pixel(24'h55AAAA);
		drain();
	endtask

	// Zero count acts as one, oversized count saturates, unknown indexes do nothing
	task automatic test_led_count_limits;
		write_reg(REG_LED_COUNT, '0);
		send_pixel(24'h123456);
		send_pixel(24'h654321);
		drain();
		write_reg(REG_LED_COUNT, CFG_DATA_W'(2047));
		send_pixel(24'h0F0F0F);
		send_pixel(24'hF0F0F0);
		drain();
		write_reg(REG_LED_COUNT, CFG_DATA_W'(MAX_LEDS));
		for (int k = int'(REG_LED_COUNT) + 1; k < (1 << CFG_IDX_W); k++)
			write_reg(CFG_IDX_W'(k), '1);
		send_pixel(24'h800001);
		drain();
	endtask

	// Shrink the frame while the position is past its new end
	task automatic test_shrunken_frame;
		write_reg(REG_LED_COUNT, CFG_DATA_W'(1));
		send_pixel(24'h010203);
		drain();
		write_reg(REG_LED_COUNT, CFG_DATA_W'(8));
		for (int k = 0; k < 5; k++)
			send_pixel(PIXEL_W'($urandom));
		drain();
		write_reg(REG_LED_COUNT, CFG_DATA_W'(2));
		for (int k = 0; k < 3; k++)
			send_pixel(PIXEL_W'($urandom));
		drain();
	endtask

	// Random settings and pixels under each idling pattern
	task automatic test_random_traffic;
		int n;
		logic [PIXEL_W-1:0] pix;
		for (int phase = 0; phase < 12; phase++) begin
			case (phase / 4)
				0: set_idle(35, 76);
				1: set_idle(76, 35);
				default: set_idle(0, 0);
			endcase
			pick_settings();
			n = $urandom_range(22, 38);
			for (int k = 0; k < n; k++) begin
				case ($urandom_range(9))
					0: pix = '0;
					1: pix = '1;
					default: pix = PIXEL_W'($urandom);
				endcase
				send_pixel(pix);
			end
			drain();
		end
	endtask

	// Reset, run the tests in turn, then report
	initial begin
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_index      <= '0;
		cfg_wdata      <= '0;
		pixel_ch.valid <= 1'b0;
		pixel_ch.pixel <= '0;
		cur_order      = RST_COLOR_ORDER;
		cur_one_high   = RST_ONE_HIGH;
		cur_zero_high  = RST_ZERO_HIGH;
		cur_low        = RST_LOW;
		cur_led_count  = RST_LED_COUNT;
		frame_pos      = 0;
		set_idle(35, 76);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_values();
		test_color_orders();
		test_pulse_extremes();
		test_led_count_limits();
		test_shrunken_frame();
		test_random_traffic();

		drain();
		repeat (2 * SETTLE) @(posedge clk);
		if (mismatch_total == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
